### hw/rtl/sbf_pkg.sv
// ----------------------------------------------------------------------------
// sbf_pkg
// Types, widths and register indexes shared by the spring force pipeline.
// ----------------------------------------------------------------------------
package sbf_pkg;

    localparam int N_AX    = 3;    // x, y, z
    localparam int COORD_W = 32;   // signed Q16.16 coordinate
    localparam int D_W     = 33;   // exact difference of two coordinates
    localparam int MAG_W   = 32;   // magnitude of a difference
    localparam int SQ_W    = 64;   // square of a magnitude
    localparam int RAD_W   = 66;   // sum of three squares
    localparam int ROOT_W  = 33;   // spring length
    localparam int REM_W   = 34;   // square root remainder
    localparam int K_W     = 32;   // stiffness
    localparam int KP_W    = 65;   // extension times stiffness
    localparam int M_W     = 49;   // scaled force magnitude
    localparam int ML_W    = 25;   // low slice of m for the partial products
    localparam int PL_W    = ML_W + MAG_W;          // 57
    localparam int PH_W    = (M_W - ML_W) + MAG_W;  // 56
    localparam int P_W     = M_W + MAG_W;           // 81
    localparam int Q_W     = 32;   // quotient bits kept
    localparam int PHI_W   = P_W - Q_W;             // 49
    localparam int DREM_W  = ROOT_W;                // divider remainder
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 32;

    localparam logic [K_W-1:0]    K_RESET    = 32'd65536;
    localparam logic [ROOT_W-2:0] REST_RESET = 32'd65536;

    typedef enum logic [CFG_AW-1:0] {
        REG_SPRING_K = 2'd0,
        REG_REST_LEN = 2'd1,
        REG_BUNGEE   = 2'd2
    } sbf_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
    } sbf_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] force_x;
        logic signed [COORD_W-1:0] force_y;
        logic signed [COORD_W-1:0] force_z;
        logic                      slack;
        logic                      overflow;
    } sbf_out_t;

    // Side data that rides along the square root stages.
    typedef struct packed {
        logic [N_AX-1:0][MAG_W-1:0] mag;
        logic [N_AX-1:0]            neg;
    } sbf_sq_tag_t;

    // Side data that rides along the divider stages.
    typedef struct packed {
        logic            e_neg;
        logic            slack;
        logic            zero;
        logic [N_AX-1:0] neg;
    } sbf_dv_tag_t;

endpackage

### hw/rtl/sbf_sqrt.sv
// ----------------------------------------------------------------------------
// sbf_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module sbf_sqrt
    import sbf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [RAD_W-1:0]    in_rad,
    input  sbf_sq_tag_t         in_tag,
    output logic                out_valid,
    output logic [ROOT_W-1:0]   out_root,
    output sbf_sq_tag_t         out_tag
);

    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic              v_reg    [ROOT_W];
    sbf_sq_tag_t       tag_reg  [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        localparam int BI = ROOT_W - 1 - j;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic              v_in;
        sbf_sq_tag_t       tag_in;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (j == 0) begin : g_first
            assign rad_in  = in_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign v_in    = in_valid;
            assign tag_in  = in_tag;
        end else begin : g_next
            assign rad_in  = rad_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign v_in    = v_reg[j-1];
            assign tag_in  = tag_reg[j-1];
        end

        assign rem_sh = {rem_in, rad_in[2*BI+1 -: 2]};
        assign trial  = (REM_W+2)'({root_in, 2'b01});

        always_comb begin
            if (rem_sh >= trial) begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {root_in[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh[REM_W-1:0];
                root_next = {root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[j]  <= rad_in;
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
                tag_reg[j]  <= tag_in;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_tag   = tag_reg[ROOT_W-1];

endmodule

### hw/rtl/sbf_div.sv
// ----------------------------------------------------------------------------
// sbf_div
// Three-lane pipelined restoring divider: a range check stage, then one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module sbf_div
    import sbf_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [ROOT_W-1:0]             in_len,
    input  logic [N_AX-1:0][P_W-1:0]      in_num,
    input  sbf_dv_tag_t                   in_tag,
    output logic                          out_valid,
    output logic [N_AX-1:0][Q_W-1:0]      out_q,
    output logic [N_AX-1:0]               out_big,
    output sbf_dv_tag_t                   out_tag
);

    // Range check stage: quotient needs more than Q_W bits when the high
    // part of the numerator already reaches the divisor.
    logic                          v0_reg;
    logic [ROOT_W-1:0]             len0_reg;
    logic [N_AX-1:0][DREM_W-1:0]   rem0_reg;
    logic [N_AX-1:0][Q_W-1:0]      lo0_reg;
    logic [N_AX-1:0]               big0_reg;
    sbf_dv_tag_t                   tag0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            len0_reg <= in_len;
            tag0_reg <= in_tag;
            for (int i = 0; i < N_AX; i++) begin
                big0_reg[i] <= in_num[i][P_W-1:Q_W] >= PHI_W'(in_len);
                rem0_reg[i] <= in_num[i][Q_W+DREM_W-1:Q_W];
                lo0_reg[i]  <= in_num[i][Q_W-1:0];
            end
        end
    end

    logic                          v_reg   [Q_W];
    logic [ROOT_W-1:0]             len_reg [Q_W];
    logic [N_AX-1:0][DREM_W-1:0]   rem_reg [Q_W];
    logic [N_AX-1:0][Q_W-1:0]      lo_reg  [Q_W];
    logic [N_AX-1:0][Q_W-1:0]      q_reg   [Q_W];
    logic [N_AX-1:0]               big_reg [Q_W];
    sbf_dv_tag_t                   tag_reg [Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_stage
        localparam int BI = Q_W - 1 - j;
        logic                          v_in;
        logic [ROOT_W-1:0]             len_in;
        logic [N_AX-1:0][DREM_W-1:0]   rem_in;
        logic [N_AX-1:0][Q_W-1:0]      lo_in;
        logic [N_AX-1:0][Q_W-1:0]      q_in;
        logic [N_AX-1:0]               big_in;
        sbf_dv_tag_t                   tag_in;
        logic [N_AX-1:0][DREM_W-1:0]   rem_next;
        logic [N_AX-1:0][Q_W-1:0]      q_next;

        if (j == 0) begin : g_first
            assign v_in   = v0_reg;
            assign len_in = len0_reg;
            assign rem_in = rem0_reg;
            assign lo_in  = lo0_reg;
            assign q_in   = '0;
            assign big_in = big0_reg;
            assign tag_in = tag0_reg;
        end else begin : g_next
            assign v_in   = v_reg[j-1];
            assign len_in = len_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign lo_in  = lo_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign big_in = big_reg[j-1];
            assign tag_in = tag_reg[j-1];
        end

        always_comb begin
            logic [DREM_W:0] r2;
            for (int i = 0; i < N_AX; i++) begin
                r2 = {rem_in[i], lo_in[i][BI]};
                if (r2 >= (DREM_W+1)'(len_in)) begin
                    rem_next[i] = DREM_W'(r2 - (DREM_W+1)'(len_in));
                    q_next[i]   = {q_in[i][Q_W-2:0], 1'b1};
                end else begin
                    rem_next[i] = r2[DREM_W-1:0];
                    q_next[i]   = {q_in[i][Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                len_reg[j] <= len_in;
                rem_reg[j] <= rem_next;
                lo_reg[j]  <= lo_in;
                q_reg[j]   <= q_next;
                big_reg[j] <= big_in;
                tag_reg[j] <= tag_in;
            end
        end
    end

    assign out_valid = v_reg[Q_W-1];
    assign out_q     = q_reg[Q_W-1];
    assign out_big   = big_reg[Q_W-1];
    assign out_tag   = tag_reg[Q_W-1];

endmodule

### hw/rtl/spring_bungee_force.sv
// ----------------------------------------------------------------------------
// spring_bungee_force
// Hooke spring / bungee force on a point from a second point or anchor.
// ----------------------------------------------------------------------------
// Each request carries two points in signed Q16.16; the response is the force
// on the first point, -k*(L - rest)*d/L, with each component rounded toward
// zero and saturated to 32 bits. The pipeline takes one request per clock.
// Registered stages form the differences and the sum of squares, the square
// root stages form the length (one root bit per stage), further stages scale
// by the extension and stiffness, the divider stages divide by the length (a
// range check, then one quotient bit per stage) and the result is saturated
// into the output register. A stall on the response side freezes every stage
// at once, so nothing is dropped or repeated. Write the configuration
// registers only while no request is in flight.
// ----------------------------------------------------------------------------
module spring_bungee_force
    import sbf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CFG_AW-1:0]  cfg_addr,
    input  logic [CFG_DW-1:0]  cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  sbf_in_t            s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sbf_out_t           m_data
);

    // Configuration registers.
    logic [K_W-1:0]    k_reg;
    logic [K_W-1:0]    rest_reg;
    logic              bungee_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg      <= K_RESET;
            rest_reg   <= REST_RESET;
            bungee_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SPRING_K: k_reg      <= cfg_wdata;
                REG_REST_LEN: rest_reg   <= cfg_wdata;
                REG_BUNGEE:   bungee_reg <= cfg_wdata[0];
                default:      ;  // drop writes to unused indexes
            endcase
        end
    end

    // Whole pipeline advances together; the output register frees up when
    // the response is taken.
    logic adv;
    logic out_valid_reg;
    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    // Stage 1: exact differences.
    logic [N_AX-1:0][COORD_W-1:0] pa, pb;
    assign pa = {s_data.first_x, s_data.first_y, s_data.first_z};
    assign pb = {s_data.second_x, s_data.second_y, s_data.second_z};

    logic                        v1_reg;
    logic [N_AX-1:0][D_W-1:0]    d_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < N_AX; i++) begin
                d_reg[i] <= {pa[i][COORD_W-1], pa[i]} - {pb[i][COORD_W-1], pb[i]};
            end
        end
    end

    // Stage 2: magnitudes and signs.
    logic                        v2_reg;
    logic [N_AX-1:0][MAG_W-1:0]  mag2_reg;
    logic [N_AX-1:0]             neg2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < N_AX; i++) begin
                neg2_reg[i] <= d_reg[i][D_W-1];
                mag2_reg[i] <= d_reg[i][D_W-1] ? MAG_W'(-d_reg[i]) : d_reg[i][MAG_W-1:0];
            end
        end
    end

    // Stage 3: squares.
    logic                        v3_reg;
    logic [N_AX-1:0][SQ_W-1:0]   sq_reg;
    sbf_sq_tag_t                 tag3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < N_AX; i++) begin
                sq_reg[i] <= SQ_W'(mag2_reg[i]) * SQ_W'(mag2_reg[i]);
            end
            tag3_reg.mag <= mag2_reg;
            tag3_reg.neg <= neg2_reg;
        end
    end

    // Stage 4: sum of squares.
    logic                        v4_reg;
    logic [RAD_W-1:0]            sum_reg;
    sbf_sq_tag_t                 tag4_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg  <= RAD_W'(sq_reg[0]) + RAD_W'(sq_reg[1]) + RAD_W'(sq_reg[2]);
            tag4_reg <= tag3_reg;
        end
    end

    // Length.
    logic                 sq_valid;
    logic [ROOT_W-1:0]    len;
    sbf_sq_tag_t          sq_tag;

    sbf_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v4_reg),
        .in_rad    (sum_reg),
        .in_tag    (tag4_reg),
        .out_valid (sq_valid),
        .out_root  (len),
        .out_tag   (sq_tag)
    );

    // Stage 5: extension, bungee slack and the zero length case.
    logic [ROOT_W-1:0] rest_ext;
    logic              len_short;
    assign rest_ext  = ROOT_W'(rest_reg);
    assign len_short = len < rest_ext;

    logic                        v5_reg;
    logic [ROOT_W-1:0]           emag_reg;
    logic [ROOT_W-1:0]           len5_reg;
    logic [N_AX-1:0][MAG_W-1:0]  mag5_reg;
    sbf_dv_tag_t                 tag5_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            emag_reg       <= len_short ? rest_ext - len : len - rest_ext;
            len5_reg       <= len;
            mag5_reg       <= sq_tag.mag;
            tag5_reg.e_neg <= len_short;
            tag5_reg.slack <= bungee_reg && (len <= rest_ext);
            tag5_reg.zero  <= (bungee_reg && (len <= rest_ext)) || (len == '0);
            tag5_reg.neg   <= sq_tag.neg;
        end
    end

    // Stage 6: m = k * |e| in Q16.16.
    logic [KP_W-1:0] kprod;
    assign kprod = KP_W'(emag_reg) * KP_W'(k_reg);

    logic                        v6_reg;
    logic [M_W-1:0]              m_reg;
    logic [ROOT_W-1:0]           len6_reg;
    logic [N_AX-1:0][MAG_W-1:0]  mag6_reg;
    sbf_dv_tag_t                 tag6_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_reg    <= kprod[KP_W-1:16];
            len6_reg <= len5_reg;
            mag6_reg <= mag5_reg;
            tag6_reg <= tag5_reg;
        end
    end

    // Stage 7: m * |d_i| split into two partial products per axis.
    logic                        v7_reg;
    logic [N_AX-1:0][PL_W-1:0]   pl_reg;
    logic [N_AX-1:0][PH_W-1:0]   ph_reg;
    logic [ROOT_W-1:0]           len7_reg;
    sbf_dv_tag_t                 tag7_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < N_AX; i++) begin
                pl_reg[i] <= PL_W'(m_reg[ML_W-1:0]) * PL_W'(mag6_reg[i]);
                ph_reg[i] <= PH_W'(m_reg[M_W-1:ML_W]) * PH_W'(mag6_reg[i]);
            end
            len7_reg <= len6_reg;
            tag7_reg <= tag6_reg;
        end
    end

    // Stage 8: combine the partial products.
    logic                        v8_reg;
    logic [N_AX-1:0][P_W-1:0]    p_reg;
    logic [ROOT_W-1:0]           len8_reg;
    sbf_dv_tag_t                 tag8_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < N_AX; i++) begin
                p_reg[i] <= {ph_reg[i], {ML_W{1'b0}}} + P_W'(pl_reg[i]);
            end
            len8_reg <= len7_reg;
            tag8_reg <= tag7_reg;
        end
    end

    // Divide by the length. The quotient never exceeds m because |d_i| <= L.
    logic                        dv_valid;
    logic [N_AX-1:0][Q_W-1:0]    dv_q;
    logic [N_AX-1:0]             dv_big;
    sbf_dv_tag_t                 dv_tag;

    sbf_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v8_reg),
        .in_len    (len8_reg),
        .in_num    (p_reg),
        .in_tag    (tag8_reg),
        .out_valid (dv_valid),
        .out_q     (dv_q),
        .out_big   (dv_big),
        .out_tag   (dv_tag)
    );

    // Output stage: sign, saturate, flags.
    logic [N_AX-1:0][COORD_W-1:0] f_next;
    logic [N_AX-1:0]              sat;

    always_comb begin
        for (int i = 0; i < N_AX; i++) begin
            if (dv_tag.zero) begin
                sat[i]    = 1'b0;
                f_next[i] = '0;
            end else if (dv_tag.e_neg != dv_tag.neg[i]) begin
                sat[i]    = dv_big[i] || dv_q[i][Q_W-1];
                f_next[i] = sat[i] ? {1'b0, {(COORD_W-1){1'b1}}} : dv_q[i];
            end else begin
                sat[i]    = dv_big[i] || (dv_q[i] > {1'b1, {(Q_W-1){1'b0}}});
                f_next[i] = sat[i] ? {1'b1, {(COORD_W-1){1'b0}}} : -dv_q[i];
            end
        end
    end

    sbf_out_t out_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg.force_x  <= f_next[2];
            out_reg.force_y  <= f_next[1];
            out_reg.force_z  <= f_next[0];
            out_reg.slack    <= dv_tag.slack;
            out_reg.overflow <= |sat;
        end
    end

    // Valid bits for the stages held in this module.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg        <= s_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= sq_valid;
            v6_reg        <= v5_reg;
            v7_reg        <= v6_reg;
            v8_reg        <= v7_reg;
            out_valid_reg <= dv_valid;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Slack responses carry zero force and never overflow.
    a_slack_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.slack |-> m_data.force_x == '0 && m_data.force_y == '0
            && m_data.force_z == '0 && !m_data.overflow)
        else $error("slack response with nonzero force or overflow");

    // Slack only shows up in bungee mode.
    a_slack_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.slack |-> bungee_reg)
        else $error("slack flag outside bungee mode");

    // An overflow means some component sits on a saturation value.
    a_ovf_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.overflow |->
            m_data.force_x == 32'sh7FFFFFFF || m_data.force_x == 32'sh80000000 ||
            m_data.force_y == 32'sh7FFFFFFF || m_data.force_y == 32'sh80000000 ||
            m_data.force_z == 32'sh7FFFFFFF || m_data.force_z == 32'sh80000000)
        else $error("overflow flag without a saturated component");

    // A held response stays valid and unchanged during a stall.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("response lost during stall");

endmodule

### verif/tb_spring_bungee_force.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spring_bungee_force
// Self-checking bench for the spring / bungee force pipeline.
// ----------------------------------------------------------------------------
// A queue of requests, filled phase by phase, feeds a clocked driver. A clocked
// monitor takes each response and compares it, field by field, against the
// oldest force that the bench itself has computed for an accepted request.
// Phases change the spring settings only after the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_spring_bungee_force
    import sbf_pkg::*;
;

    localparam int PIPE_LAT = 75;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_DW-1:0] cfg_wdata = '0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    sbf_in_t   s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    sbf_out_t  m_data;

    spring_bungee_force DUT (.*);

    always #10 aclk = ~aclk;

    // Spring settings as the bench believes them to be.
    logic [31:0] k_val = 32'd65536;
    logic [31:0] rest_val = 32'd65536;
    logic        bungee_on = 1'b0;

    sbf_in_t  pending_reqs[$];
    sbf_out_t expected_forces[$];
    int       fail_count = 0;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_cycles = 0;

    // Integer square root of a 66-bit value, one result bit per step.
    function automatic logic [32:0] root66(logic [65:0] v);
        logic [67:0] rem;
        logic [32:0] root;
        logic [67:0] trial;
        rem = '0;
        root = '0;
        for (int i = 33; i >= 0; i--) begin
            rem = (rem << 2) | ((v >> (2 * i)) & 66'd3);
            trial = ({35'd0, root} << 2) | 68'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 33'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic sbf_out_t spring_force(sbf_in_t r);
        logic signed [32:0] d[3];
        logic [31:0] mag[3];
        logic [65:0] sum_sq;
        logic [32:0] len;
        logic [32:0] ext;
        logic        compressed;
        logic [64:0] kp;
        logic [48:0] m;
        logic [80:0] q;
        logic        ovf;
        sbf_out_t    f;
        logic signed [31:0] comp[3];
        d[0] = $signed(r.first_x) - $signed(r.second_x);
        d[1] = $signed(r.first_y) - $signed(r.second_y);
        d[2] = $signed(r.first_z) - $signed(r.second_z);
        sum_sq = '0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = d[i] < 0 ? 32'(-d[i]) : 32'(d[i]);
            sum_sq += 66'(mag[i]) * 66'(mag[i]);
        end
        len = root66(sum_sq);
        f = '0;
        if (bungee_on && len <= {1'b0, rest_val}) begin
            f.slack = 1'b1;
            return f;
        end
        if (len == 0) return f;
        compressed = len < {1'b0, rest_val};
        ext = compressed ? {1'b0, rest_val} - len : len - {1'b0, rest_val};
        kp = 65'(ext) * 65'(k_val);
        m = kp[64:16];
        ovf = 1'b0;
        for (int i = 0; i < 3; i++) begin
            q = (81'(m) * 81'(mag[i])) / 81'(len);
            if (compressed != (d[i] < 0)) begin
                if (q > 81'h7FFFFFFF) begin
                    q = 81'h7FFFFFFF;
                    ovf = 1'b1;
                end
                comp[i] = q[31:0];
            end else begin
                if (q > 81'h80000000) begin
                    q = 81'h80000000;
                    ovf = 1'b1;
                end
                comp[i] = -q[31:0];
            end
        end
        f.force_x = comp[0];
        f.force_y = comp[1];
        f.force_z = comp[2];
        f.overflow = ovf;
        return f;
    endfunction

    // Driver: present the head of the queue, hold it until accepted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_forces = {expected_forces, spring_force(s_data)};
                void'(pending_reqs.pop_front());
            end
            if ((!s_valid || s_ready) && pending_reqs.size() > 0
                    && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data <= pending_reqs[0];
            end else if (!s_valid || s_ready) begin
                s_valid <= 1'b0;
            end
        end
    end

    // Long hold-off counter for the back-pressure phase.
    always @(posedge aclk) begin
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    // Monitor: check each response and pick a new ready.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_forces.size() == 0) begin
                    $display("%0t: response with none pending: %h", $time, m_data);
                    fail_count++;
                end else begin
                    sbf_out_t exp_f;
                    exp_f = expected_forces.pop_front();
                    if (m_data.force_x !== exp_f.force_x)
                        $display("%0t: force_x expected %h got %h", $time,
                                 exp_f.force_x, m_data.force_x);
                    if (m_data.force_y !== exp_f.force_y)
                        $display("%0t: force_y expected %h got %h", $time,
                                 exp_f.force_y, m_data.force_y);
                    if (m_data.force_z !== exp_f.force_z)
                        $display("%0t: force_z expected %h got %h", $time,
                                 exp_f.force_z, m_data.force_z);
                    if (m_data.slack !== exp_f.slack)
                        $display("%0t: slack expected %b got %b", $time,
                                 exp_f.slack, m_data.slack);
                    if (m_data.overflow !== exp_f.overflow)
                        $display("%0t: overflow expected %b got %b", $time,
                                 exp_f.overflow, m_data.overflow);
                    if (m_data !== exp_f) fail_count++;
                end
            end
            m_ready <= hold_cycles == 0 && $urandom_range(99) >= recv_stall_pct;
        end
    end

    // Wait for the pipeline to drain completely, then let it settle.
    task automatic drain_pipe();
        while (pending_reqs.size() != 0 || s_valid || expected_forces.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LAT + 5) @(posedge aclk);
    endtask

    task automatic write_reg(sbf_reg_t idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_SPRING_K: k_val = val;
            REG_REST_LEN: rest_val = val;
            REG_BUNGEE:   bungee_on = val[0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_coord(int scale);
        case (scale)
            0: return $urandom_range(8) << 16;             // small integers
            1: return 32'($signed($urandom_range(65535 * 8)) - 65535 * 4);
            2: return {{8{$urandom_range(1) ? 1'b1 : 1'b0}}, 24'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic sbf_in_t rand_req();
        sbf_in_t r;
        int scale;
        scale = $urandom_range(3);
        r.first_x = rand_coord(scale);
        r.first_y = rand_coord(scale);
        r.first_z = rand_coord(scale);
        // Anchor sometimes sits on the point, or nearby.
        if ($urandom_range(15) == 0) begin
            r.second_x = r.first_x;
            r.second_y = r.first_y;
            r.second_z = r.first_z;
        end else begin
            r.second_x = rand_coord(scale);
            r.second_y = rand_coord(scale);
            r.second_z = rand_coord(scale);
        end
        return r;
    endfunction

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++) pending_reqs = {pending_reqs, rand_req()};
    endtask

    task automatic queue_directed();
        sbf_in_t r;
        logic [31:0] ext[4];
        ext = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF};
        for (int i = 0; i < 4; i++) begin
            r = '{ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4],
                  ext[(i + 2) % 4], ext[(i + 3) % 4], ext[i]};
            pending_reqs = {pending_reqs, r};
        end
        r = '0;                                          // coincident points
        pending_reqs = {pending_reqs, r};
        r = '{32'h00020000, 0, 0, 0, 0, 0};              // stretched
        pending_reqs = {pending_reqs, r};
        r = '{32'h00008000, 0, 0, 0, 0, 0};              // compressed
        pending_reqs = {pending_reqs, r};
        r = '{0, 32'hFFFF0000, 0, 0, 0, 0};              // exactly at rest
        pending_reqs = {pending_reqs, r};
        r = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
              32'h80000000, 32'h80000000, 32'h80000000}; // longest spring
        pending_reqs = {pending_reqs, r};
        r = '{0, 0, 32'h00000001, 0, 0, 0};              // one ulp apart
        pending_reqs = {pending_reqs, r};
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings, directed requests, no idling.
        queue_directed();
        drain_pipe();

        // Bungee mode at the same settings.
        write_reg(REG_BUNGEE, 32'd1);
        queue_directed();
        drain_pipe();

        // Extremes of stiffness and rest length.
        write_reg(REG_SPRING_K, 32'hFFFFFFFF);
        write_reg(REG_REST_LEN, 32'h0);
        write_reg(REG_BUNGEE, 32'hFFFFFFFE);
        queue_directed();
        queue_random(150);
        drain_pipe();

        write_reg(REG_SPRING_K, 32'h0);
        write_reg(REG_REST_LEN, 32'hFFFFFFFF);
        write_reg(REG_BUNGEE, 32'd1);
        send_idle_pct = 73;
        queue_random(150);
        drain_pipe();

        // Mid settings with the receiver stalling.
        write_reg(REG_SPRING_K, 32'h00018000);
        write_reg(REG_REST_LEN, 32'h00030000);
        write_reg(REG_BUNGEE, 32'd0);
        send_idle_pct = 0;
        recv_stall_pct = 73;
        queue_random(150);
        drain_pipe();

        // Long hold-off so the pipeline fills and stalls its input.
        hold_cycles = 200;
        recv_stall_pct = 0;
        queue_random(150);
        drain_pipe();

        // Random settings, both sides idling.
        write_reg(REG_SPRING_K, $urandom);
        write_reg(REG_REST_LEN, $urandom >> $urandom_range(31));
        write_reg(REG_BUNGEE, $urandom);
        send_idle_pct = 30;
        recv_stall_pct = 30;
        queue_random(150);
        drain_pipe();

        // Write to an unused index: the settings must stay as they are.
        cfg_wr_en <= 1'b1;
        cfg_addr <= 2'd3;
        cfg_wdata <= $urandom;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        write_reg(REG_SPRING_K, 32'h00004000);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_random(130);
        drain_pipe();

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/sbf_pkg.sv
hw/rtl/sbf_sqrt.sv
hw/rtl/sbf_div.sv
hw/rtl/spring_bungee_force.sv
verif/tb_spring_bungee_force.sv
